FILE: src/dre_pkg.sv
// Shared types and constants for the drip rate estimator.
// No dependencies; used by drip_rate_estimator and dre_check.
`default_nettype none
package dre_pkg;

	// field and register widths, fixed by the interface
	localparam int TC_W   = 20;
	localparam int CUT_W  = 20;
	localparam int DEB_W  = 16;
	localparam int RATE_W = 16;
	localparam int IV_W   = 24;
	localparam int NOW_W  = 32;
	localparam int CFG_W  = 20;
	localparam int IDX_W  = 2;

	// 60000 ms/min in Q8.8
	localparam logic [23:0] RATE_NUM_Q = 24'd15360000;
	localparam logic [IV_W-1:0] IV_MAX = {IV_W{1'b1}};
	localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

	// reset values
	localparam logic [TC_W-1:0]  TC_RST  = 20'd20000;
	localparam logic [CUT_W-1:0] CUT_RST = 20'd15000;
	localparam logic [DEB_W-1:0] DEB_RST = 16'd250;

	// register indexes
	localparam logic [IDX_W-1:0] REG_TC  = 2'd0;
	localparam logic [IDX_W-1:0] REG_CUT = 2'd1;
	localparam logic [IDX_W-1:0] REG_DEB = 2'd2;

	// input kinds
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_DRIP = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PREP = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} st_t;

endpackage
`default_nettype wire

FILE: src/drip_rate_estimator.sv
// Drip rate estimator: debounce, interval window, smoothed rate with a
// bit-serial multiplier and restoring divider. Depends on dre_pkg.
//
// Usage:
//  - Input stream s_*: s_tuser = mode (0 tick, 1 drip), s_tdata = now_ms.
//    One input transfer gives exactly one output transfer.
//  - Output stream m_*: m_tdata = drip_rate (Q8.8 drips/min),
//    m_tuser = {rate_cleared, drip_accepted}.
//  - Config port: cfg_we writes cfg_data into register cfg_index
//    (0 time constant, 1 cutoff, 2 debounce); other indexes are dropped.
//    Write only while the block is idle.
// Timing:
//  - Ticks and rejected drips: idle goes straight to the finish state,
//    which raises m_tvalid once the output register is free.
//  - Accepted drips: a prep state, a multiply state (shift-add over the
//    RATE_W (16) bits of the old rate), a divide state (one quotient bit
//    per cycle, NUM_W bits, 39 at defaults), then the result register.
//  - One item at a time; s_tready is high only in the idle state. An item
//    may be taken while the previous result still sits in m_tdata.
//  - If the receiver stalls, the finished result waits in the finish state
//    until the output register frees up.
// Reset: arst_n resets control and config registers, not the datapath.
`default_nettype none
module drip_rate_estimator #(
	parameter int WINDOW     = 3,
	parameter int STAMP_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] now_ms
	input  wire logic        s_tuser,   // [0] mode
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [15:0] drip_rate
	output logic [1:0]       m_tuser,   // [0] drip_accepted, [1] rate_cleared
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_data
);

	// derived widths
	localparam int N_W    = $clog2(WINDOW + 1);
	localparam int HEAD_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int TCN_W  = dre_pkg::TC_W + N_W;
	localparam int PROD_W = TCN_W + dre_pkg::RATE_W;
	localparam int KN_W   = 24 + N_W;
	localparam int NUM_W  = ((PROD_W > KN_W) ? PROD_W : KN_W) + 1;
	localparam int SUM_W  = dre_pkg::IV_W + N_W;
	localparam int DEN_W  = ((TCN_W > SUM_W) ? TCN_W : SUM_W) + 1;
	localparam int CNT_W  = $clog2(NUM_W);
	localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(WINDOW - 1);
	localparam logic [N_W-1:0]    FILL_FULL = N_W'(WINDOW);

	// configuration registers
	logic [dre_pkg::TC_W-1:0]  tc_q;
	logic [dre_pkg::CUT_W-1:0] cut_q;
	logic [dre_pkg::DEB_W-1:0] deb_q;

	// block state
	dre_pkg::st_t               state_q;
	logic [STAMP_BITS-1:0]      last_q;
	logic [dre_pkg::IV_W-1:0]   win_q [WINDOW];
	logic [SUM_W-1:0]           sum_q;    // running total of the window
	logic [N_W-1:0]             fill_q;
	logic [HEAD_W-1:0]          head_q;
	logic [dre_pkg::RATE_W-1:0] rate_q;
	logic                       armed_q;
	logic                       acc_q;    // result flags for the pending item
	logic                       clr_q;

	// arithmetic datapath
	logic [TCN_W-1:0]           tcn_q;
	logic [NUM_W-1:0]           acc_sum_q;  // numerator accumulator
	logic [NUM_W-1:0]           mcand_q;
	logic [dre_pkg::RATE_W-1:0] mplier_q;
	logic [DEN_W-1:0]           den_q;
	logic [DEN_W-1:0]           rem_q;
	logic [dre_pkg::RATE_W-1:0] quo_q;
	logic                       ovf_q;
	logic [CNT_W-1:0]           cnt_q;

	// front-end decode
	logic [STAMP_BITS-1:0]    now_sl;
	logic [STAMP_BITS-1:0]    dt;
	logic [31:0]              dt32;
	logic [dre_pkg::IV_W-1:0] iv;
	logic                     in_xfer;
	logic                     drip_ok;
	logic                     tick_clr;

	// divider step
	logic [DEN_W:0]             rem_sh;
	logic                       qbit;
	logic [DEN_W-1:0]           rem_nx;
	logic [dre_pkg::RATE_W-1:0] quo_nx;
	logic                       ovf_nx;

	assign s_tready = (state_q == dre_pkg::ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	assign now_sl   = s_tdata[STAMP_BITS-1:0];
	assign dt       = now_sl - last_q;   // wraps modulo 2^STAMP_BITS
	assign dt32     = 32'(dt);
	assign iv       = (dt32 > 32'(dre_pkg::IV_MAX)) ? dre_pkg::IV_MAX
	                                                : dt32[dre_pkg::IV_W-1:0];
	assign drip_ok  = (s_tuser == dre_pkg::MODE_DRIP) && (dt32 > 32'(deb_q));
	assign tick_clr = (s_tuser == dre_pkg::MODE_TICK) && armed_q
	                  && (dt32 >= 32'(cut_q));

	// restoring divide: one quotient bit per cycle, MSB of numerator first
	always_comb begin
		rem_sh = {rem_q, acc_sum_q[NUM_W-1]};
		qbit   = (rem_sh >= {1'b0, den_q});
		rem_nx = qbit ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
		quo_nx = {quo_q[dre_pkg::RATE_W-2:0], qbit};
		// any bit above the 16 result bits means saturation
		ovf_nx = ovf_q | quo_q[dre_pkg::RATE_W-1];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q  <= dre_pkg::TC_RST;
			cut_q <= dre_pkg::CUT_RST;
			deb_q <= dre_pkg::DEB_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dre_pkg::REG_TC:  tc_q  <= cfg_data[dre_pkg::TC_W-1:0];
				dre_pkg::REG_CUT: cut_q <= cfg_data[dre_pkg::CUT_W-1:0];
				dre_pkg::REG_DEB: deb_q <= cfg_data[dre_pkg::DEB_W-1:0];
				default: ;
			endcase
		end
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dre_pkg::ST_IDLE;
			last_q   <= '0;
			for (int i = 0; i < WINDOW; i++) win_q[i] <= '0;
			sum_q    <= '0;
			fill_q   <= '0;
			head_q   <= '0;
			rate_q   <= '0;
			armed_q  <= 1'b0;
			acc_q    <= 1'b0;
			clr_q    <= 1'b0;
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			// the finish state reloads the output itself
			if (m_tvalid && m_tready && (state_q != dre_pkg::ST_FIN))
				m_tvalid <= 1'b0;

			case (state_q)
				dre_pkg::ST_IDLE: begin
					if (in_xfer) begin
						acc_q   <= drip_ok;
						clr_q   <= tick_clr;
						state_q <= drip_ok ? dre_pkg::ST_PREP : dre_pkg::ST_FIN;
						if (drip_ok) begin
							win_q[head_q] <= iv;
							sum_q   <= sum_q - SUM_W'(win_q[head_q]) + SUM_W'(iv);
							head_q  <= (head_q == HEAD_LAST) ? '0 : head_q + 1'b1;
							if (fill_q != FILL_FULL) fill_q <= fill_q + 1'b1;
							last_q  <= now_sl;
							armed_q <= 1'b1;
						end
						if (tick_clr) begin
							rate_q  <= '0;
							armed_q <= 1'b0;
						end
					end
				end
				dre_pkg::ST_PREP: begin
					cnt_q   <= CNT_W'(dre_pkg::RATE_W - 1);
					state_q <= dre_pkg::ST_MUL;
				end
				dre_pkg::ST_MUL: begin
					if (cnt_q == '0) begin
						cnt_q   <= CNT_W'(NUM_W - 1);
						state_q <= dre_pkg::ST_DIV;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				dre_pkg::ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						rate_q  <= ovf_nx ? dre_pkg::RATE_MAX : quo_nx;
						state_q <= dre_pkg::ST_FIN;
					end
				end
				dre_pkg::ST_FIN: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						state_q  <= dre_pkg::ST_IDLE;
					end
				end
				default: state_q <= dre_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			dre_pkg::ST_PREP: begin
				// tc*n and 60000*256*n are narrow-by-tiny products
				tcn_q     <= TCN_W'(tc_q) * TCN_W'(fill_q);
				mcand_q   <= NUM_W'(TCN_W'(tc_q) * TCN_W'(fill_q));
				acc_sum_q <= NUM_W'(KN_W'(dre_pkg::RATE_NUM_Q) * KN_W'(fill_q));
				mplier_q  <= rate_q;
			end
			dre_pkg::ST_MUL: begin
				// shift-add, LSB of the old rate first
				if (mplier_q[0]) acc_sum_q <= acc_sum_q + mcand_q;
				mcand_q  <= {mcand_q[NUM_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[dre_pkg::RATE_W-1:1]};
				if (cnt_q == '0) begin
					den_q <= DEN_W'(tcn_q) + DEN_W'(sum_q);
					rem_q <= '0;
					quo_q <= '0;
					ovf_q <= 1'b0;
				end
			end
			dre_pkg::ST_DIV: begin
				acc_sum_q <= {acc_sum_q[NUM_W-2:0], 1'b0};
				rem_q     <= rem_nx;
				quo_q     <= quo_nx;
				ovf_q     <= ovf_nx;
			end
			dre_pkg::ST_FIN: begin
				if (!m_tvalid || m_tready) begin
					m_tdata <= rate_q;
					m_tuser <= {clr_q, acc_q};
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: src/dre_check.sv
// Port-level checks for drip_rate_estimator, bound to the top level.
// Depends on dre_pkg only for widths.
`default_nettype none
module dre_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [dre_pkg::RATE_W-1:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	// a cleared rate is reported as zero
	a_clr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == '0)
		else $error("rate_cleared with nonzero rate");

	// a result is either a drip or a tick outcome, never both
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("both result flags set");

	// one item at a time: no back-to-back input transfers
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed under stall");

endmodule

bind drip_rate_estimator dre_check u_dre_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

FILE: tb/dre_check.sv
// Scoreboard for the drip rate estimator: mirrors register writes, predicts
// every result from the input transfers and checks the output stream.
// Depends on dre_pkg.
`timescale 1ns / 1ps
module dre_scoreboard #(
	parameter int WINDOW = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [dre_pkg::NOW_W-1:0]  s_tdata,   // [31:0] now_ms
	input  logic                       s_tuser,   // [0] mode
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [dre_pkg::RATE_W-1:0] m_tdata,   // [15:0] drip_rate
	input  logic [1:0]                 m_tuser,   // [0] drip_accepted, [1] rate_cleared
	input  logic                       cfg_we,
	input  logic [dre_pkg::IDX_W-1:0]  cfg_index,
	input  logic [dre_pkg::CFG_W-1:0]  cfg_data,
	output int                         fail_count,
	output int                         pending
);

	typedef struct packed {
		logic [dre_pkg::RATE_W-1:0] rate;
		logic                       accepted;
		logic                       cleared;
	} reading_t;

	reading_t          expected_readings[$];

	// mirrored registers and meter state
	logic [dre_pkg::TC_W-1:0]   tc_ms;
	logic [dre_pkg::CUT_W-1:0]  cutoff_ms;
	logic [dre_pkg::DEB_W-1:0]  debounce_ms;
	logic [dre_pkg::NOW_W-1:0]  last_stamp;
	logic [dre_pkg::IV_W-1:0]   intervals[WINDOW];
	int unsigned                fill;
	int unsigned                head;
	logic [dre_pkg::RATE_W-1:0] rate;
	logic                       armed;
	int                         fails;

	// advance the meter by one input and return the reading it produces
	function automatic reading_t predict_reading(input logic mode,
			input logic [dre_pkg::NOW_W-1:0] now);
		logic [dre_pkg::NOW_W-1:0] dt;
		logic [dre_pkg::IV_W-1:0]  iv;
		logic [63:0]      total;
		logic [63:0]      tcn;
		logic [63:0]      num;
		logic [63:0]      den;
		logic [63:0]      quot;
		reading_t         r;
		r = '0;
		dt = now - last_stamp;
		if (mode == dre_pkg::MODE_DRIP) begin
			if (dt > debounce_ms) begin
				iv = (dt > dre_pkg::NOW_W'(dre_pkg::IV_MAX)) ? dre_pkg::IV_MAX
				                                             : dt[dre_pkg::IV_W-1:0];
				intervals[head] = iv;
				head = (head + 1 >= WINDOW) ? 0 : head + 1;
				if (fill < WINDOW)
					fill++;
				total = '0;
				for (int i = 0; i < WINDOW; i++)
					total += 64'(intervals[i]);
				tcn  = 64'(tc_ms) * 64'(fill);
				num  = tcn * 64'(rate) + 64'(dre_pkg::RATE_NUM_Q) * 64'(fill);
				den  = tcn + total;
				quot = (den != 0) ? num / den : 64'(dre_pkg::RATE_MAX);
				rate = (quot > 64'(dre_pkg::RATE_MAX)) ? dre_pkg::RATE_MAX
				                                       : quot[dre_pkg::RATE_W-1:0];
				last_stamp = now;
				armed = 1'b1;
				r.accepted = 1'b1;
			end
		end else if (armed && dt >= cutoff_ms) begin
			rate = '0;
			armed = 1'b0;
			r.cleared = 1'b1;
		end
		r.rate = rate;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		reading_t want;
		if (!arst_n) begin
			tc_ms = dre_pkg::TC_RST;
			cutoff_ms = dre_pkg::CUT_RST;
			debounce_ms = dre_pkg::DEB_RST;
			last_stamp = '0;
			for (int i = 0; i < WINDOW; i++)
				intervals[i] = '0;
			fill = 0;
			head = 0;
			rate = '0;
			armed = 1'b0;
			fails = 0;
			expected_readings.delete();
		end else begin
			// the result leaving now always belongs to an older input
			if (m_tvalid && m_tready) begin
				if (expected_readings.size() == 0) begin
					$error("drip_rate: no result expected, got %0d", m_tdata);
					fails++;
				end else begin
					want = expected_readings[0];
					expected_readings.delete(0);
					if (m_tdata !== want.rate) begin
						$error("drip_rate: expected %0d, got %0d", want.rate, m_tdata);
						fails++;
					end
					if (m_tuser[0] !== want.accepted) begin
						$error("drip_accepted: expected %0d, got %0d",
							want.accepted, m_tuser[0]);
						fails++;
					end
					if (m_tuser[1] !== want.cleared) begin
						$error("rate_cleared: expected %0d, got %0d",
							want.cleared, m_tuser[1]);
						fails++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					dre_pkg::REG_TC:  tc_ms = cfg_data[dre_pkg::TC_W-1:0];
					dre_pkg::REG_CUT: cutoff_ms = cfg_data[dre_pkg::CUT_W-1:0];
					dre_pkg::REG_DEB: debounce_ms = cfg_data[dre_pkg::DEB_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_readings = {expected_readings,
					predict_reading(s_tuser, s_tdata)};
		end
		fail_count <= fails;
		pending <= expected_readings.size();
	end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the drip rate estimator: clock, reset, input stimulus,
// register writes, receiver stalls, watchdog and verdict.
// Depends on dre_pkg, drip_rate_estimator and dre_scoreboard.
`timescale 1ns / 1ps
module tb_top;

	localparam int WINDOW      = 3;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 306;
	localparam int IDLE_LIMIT  = 4000;  // cycles with no transfer at all
	localparam int TAIL_CYCLES = 80;    // longer than one accepted-drip latency

	// unmapped register index, writes to it must be dropped
	localparam logic [dre_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [dre_pkg::NOW_W-1:0]  s_tdata;     // [31:0] now_ms
	logic                       s_tuser;     // [0] mode
	logic                       m_tvalid;
	logic                       m_tready;
	logic [dre_pkg::RATE_W-1:0] m_tdata;     // [15:0] drip_rate
	logic [1:0]                 m_tuser;     // [0] drip_accepted, [1] rate_cleared
	logic                       cfg_we;
	logic [dre_pkg::IDX_W-1:0]  cfg_index;
	logic [dre_pkg::CFG_W-1:0]  cfg_data;
	int                         fail_count;
	int                         pending;

	// stimulus bookkeeping
	logic [dre_pkg::NOW_W-1:0]  clock_ms;    // running stamp of the well-formed sequence
	logic [dre_pkg::CUT_W-1:0]  cut_now;     // current cutoff, shapes the tick spacing
	logic [dre_pkg::DEB_W-1:0]  deb_now;     // current debounce, shapes the drip spacing
	logic                       tx_steady;   // sender runs back to back when set

	drip_rate_estimator #(
		.WINDOW(WINDOW),
		.STAMP_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	dre_scoreboard #(
		.WINDOW(WINDOW)
	) scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: runs of ready and stall, mostly short stalls, a few long
	// ones, and now and then a long ready stretch with no back-pressure
	initial begin : receiver
		int unsigned hold;
		m_tready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				case ($urandom_range(0, 7))
					0: begin
						m_tready <= 1'b0;
						hold = $urandom_range(20, 80);
					end
					1, 2: begin
						m_tready <= 1'b0;
						hold = $urandom_range(1, 3);
					end
					3: begin
						m_tready <= 1'b1;
						hold = $urandom_range(200, 600);
					end
					default: begin
						m_tready <= 1'b1;
						hold = $urandom_range(1, 20);
					end
				endcase
			end else begin
				hold--;
			end
		end
	end

	// watchdog: any transfer or register write restarts the count
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// gap before the next input transfer: mostly none, some short, few long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (tx_steady)
			return 0;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return 0;
		if (roll < 9)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// one input transfer; tvalid stays high afterwards so a zero gap gives
	// back-to-back transfers, drain() lowers it
	task automatic send_item(input logic mode, input logic [dre_pkg::NOW_W-1:0] stamp);
		int unsigned gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= stamp;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drip_after(input logic [dre_pkg::NOW_W-1:0] ms);
		clock_ms = clock_ms + ms;
		send_item(dre_pkg::MODE_DRIP, clock_ms);
	endtask

	task automatic tick_after(input logic [dre_pkg::NOW_W-1:0] ms);
		clock_ms = clock_ms + ms;
		send_item(dre_pkg::MODE_TICK, clock_ms);
	endtask

	// hold the sender until every predicted result has left the block;
	// pending is updated at the rising edge, read here at the falling one
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [dre_pkg::IDX_W-1:0] idx,
			input logic [dre_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// registers only change while the block is empty
	task automatic set_regs(input logic [dre_pkg::TC_W-1:0] tc,
			input logic [dre_pkg::CUT_W-1:0] cut, input logic [dre_pkg::DEB_W-1:0] deb);
		drain();
		write_reg(dre_pkg::REG_TC, tc);
		write_reg(dre_pkg::REG_CUT, cut);
		write_reg(dre_pkg::REG_DEB, dre_pkg::CFG_W'(deb));
		cut_now = cut;
		deb_now = deb;
	endtask

	// mostly well-formed drip trains with ticks between them, some bounce,
	// some silence past the cutoff and a little noise anywhere on the stamp
	task automatic random_item();
		logic [dre_pkg::NOW_W-1:0] spread;
		case ($urandom_range(0, 19))
			0: begin
				clock_ms = $urandom;
				send_item(1'($urandom_range(0, 1)), clock_ms);
			end
			1, 2: drip_after($urandom_range(0, deb_now));
			3: tick_after(cut_now - $urandom_range(0, 1));
			4, 5, 6, 7, 8: tick_after($urandom_range(0, cut_now / 6 + 1));
			default: begin
				// now and then an interval long enough to saturate 24 bits
				if ($urandom_range(0, 9) == 0)
					spread = $urandom_range(1, 1 << 25);
				else
					spread = $urandom_range(1, 3000);
				drip_after(deb_now + spread);
			end
		endcase
	endtask

	initial begin : stimulus
		int phase;
		int k;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		clock_ms  = '0;
		cut_now   = dre_pkg::CUT_RST;
		deb_now   = dre_pkg::DEB_RST;
		tx_steady = 1'b0;
		arst_n    = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// --- directed part, reset register values ---
		// first drip counts from stamp zero: 100 ms is inside the debounce
		send_item(dre_pkg::MODE_DRIP, 32'd100);
		clock_ms = 32'd1000;
		send_item(dre_pkg::MODE_DRIP, clock_ms);
		drip_after(dre_pkg::DEB_RST);   // exactly the debounce gap: rejected
		drip_after(1);                  // one past it: accepted
		tick_after(dre_pkg::CUT_RST - 1); // one short of the cutoff
		tick_after(1);                  // cutoff fires, rate goes to zero
		tick_after(5000);               // nothing armed any more
		drip_after(32'h0100_0005);      // interval clamps to 24 bits
		drip_after(700);
		clock_ms = 32'hFFFF_FF00;
		send_item(dre_pkg::MODE_DRIP, clock_ms);
		drip_after(32'h300);            // stamp wraps through zero
		send_item(dre_pkg::MODE_TICK, 32'hFFFF_FFFF);

		// zero time constant: plain window average, 1 ms intervals overflow
		set_regs('0, '0, '0);
		drip_after(1);
		drip_after(1);
		drip_after(1);
		tick_after(0);                  // zero cutoff fires on the next tick
		drip_after(1);

		// upper ends of the ranges
		set_regs(20'd1000000, 20'd1000000, 16'hFFFF);
		drip_after(16'hFFFF);           // equals the debounce: rejected
		drip_after(1);
		tick_after(20'd999999);
		tick_after(1);

		// unmapped index is dropped; all-ones time constant
		drain();
		write_reg(REG_UNUSED, '1);
		write_reg(dre_pkg::REG_TC, '1);
		drip_after(32'd70000);
		drip_after(32'd66000);

		// --- random part, one register setting per phase ---
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: set_regs(dre_pkg::TC_RST, dre_pkg::CUT_RST, dre_pkg::DEB_RST);
				1: set_regs(20'd1, 20'd1, 16'd0);
				2: set_regs(20'd1000000, 20'd1000000, 16'hFFFF);
				3: set_regs(20'($urandom_range(1, 1000000)),
					20'($urandom_range(1, 1000000)), 16'($urandom));
				default: set_regs(20'($urandom_range(1, 2000)),
					20'($urandom_range(500, 5000)), 16'($urandom_range(0, 300)));
			endcase
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 50 == 0)
					tx_steady = ($urandom_range(0, 3) == 0);
				// occasional hold-off until the block is empty
				if ($urandom_range(0, 99) == 0)
					drain();
				random_item();
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
